/* design/lfsr_cycle_occurrence_stats_core_assert.svh */
// Assertion macros used by the checker file.
`ifndef LFSR_CYCLE_OCCURRENCE_STATS_CORE_ASSERT_SVH
`define LFSR_CYCLE_OCCURRENCE_STATS_CORE_ASSERT_SVH

// Checked only while out of reset.
`define LCOS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("lcos assertion failed");

// Checked at every edge, reset included.
`define LCOS_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("lcos assertion failed");

`endif

/* design/lcos_pkg.sv */
package lcos_pkg;

  localparam int MAX_LENGTH_DEF = 32;
  localparam int TAP_COUNT_DEF  = 4;
  localparam int MAX_TAPS       = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int LEN_CFG_W  = 6;
  localparam int TAP_CFG_W  = 6;
  localparam int SEED_W     = 32;
  localparam int WANT_W     = 32;
  localparam int CYC_W      = 33;
  localparam int OCC_W      = 32;
  localparam int DIV_CNT_W  = $clog2(WANT_W);
  localparam int STEP_W     = 3;

  localparam logic [LEN_CFG_W-1:0] LEN_RST  = 6'd4;
  localparam logic [SEED_W-1:0]    SEED_RST = 32'd1;
  localparam logic [TAP_CFG_W-1:0] TAP_RST [MAX_TAPS] = '{6'd4, 6'd3, 6'd0, 6'd0};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LENGTH = 3'd0,
    CFG_TAP1   = 3'd1,
    CFG_TAP2   = 3'd2,
    CFG_TAP3   = 3'd3,
    CFG_TAP4   = 3'd4,
    CFG_START  = 3'd5
  } cfg_idx_e;

  // Microprogram addresses.
  typedef enum logic [STEP_W-1:0] {
    STEP_FETCH = 3'd0,
    STEP_ADV   = 3'd1,
    STEP_CHK   = 3'd2,
    STEP_DIV   = 3'd3,
    STEP_EMIT  = 3'd4,
    STEP_WRAP  = 3'd5
  } step_e;

  typedef enum logic [2:0] {
    OP_NOP     = 3'd0,
    OP_LOAD    = 3'd1,
    OP_ADVANCE = 3'd2,
    OP_DIV     = 3'd3,
    OP_EMIT    = 3'd4
  } dp_op_e;

  typedef enum logic [2:0] {
    COND_NONE     = 3'd0,
    COND_ALWAYS   = 3'd1,
    COND_NO_TXN   = 3'd2,
    COND_LOOP     = 3'd3,
    COND_MISS     = 3'd4,
    COND_DIV_MORE = 3'd5,
    COND_OUT_BUSY = 3'd6
  } cond_e;

  typedef struct packed {
    dp_op_e op;
    cond_e  cond;
    step_e  target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic loop_more;
    logic found;
    logic div_more;
    logic out_busy;
  } status_t;

  // Control store.
  function automatic uword_t ucode_rom(step_e addr);
    uword_t w;
    case (addr)
      STEP_FETCH: w = '{op: OP_LOAD,    cond: COND_NO_TXN,   target: STEP_FETCH};
      STEP_ADV:   w = '{op: OP_ADVANCE, cond: COND_LOOP,     target: STEP_ADV};
      STEP_CHK:   w = '{op: OP_NOP,     cond: COND_MISS,     target: STEP_EMIT};
      STEP_DIV:   w = '{op: OP_DIV,     cond: COND_DIV_MORE, target: STEP_DIV};
      STEP_EMIT:  w = '{op: OP_EMIT,    cond: COND_OUT_BUSY, target: STEP_EMIT};
      STEP_WRAP:  w = '{op: OP_NOP,     cond: COND_ALWAYS,   target: STEP_FETCH};
      default:    w = '{op: OP_NOP,     cond: COND_ALWAYS,   target: STEP_FETCH};
    endcase
    return w;
  endfunction

endpackage

/* design/lcos_req_if.sv */
interface lcos_req_if
  import lcos_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [WANT_W-1:0] wanted_count;

  modport source (output valid, output wanted_count, input ready);
  modport sink   (input valid, input wanted_count, output ready);
  modport monitor (input valid, input wanted_count, input ready);
endinterface

/* design/lcos_rsp_if.sv */
interface lcos_rsp_if
  import lcos_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [CYC_W-1:0] cycle_steps;
  logic [OCC_W-1:0] most_occurrences;
  logic [OCC_W-1:0] fewest_occurrences;
  logic [OCC_W-1:0] unseen_values;
  logic             no_return;

  modport source (output valid, output cycle_steps, output most_occurrences,
                  output fewest_occurrences, output unseen_values, output no_return,
                  input ready);
  modport sink   (input valid, input cycle_steps, input most_occurrences,
                  input fewest_occurrences, input unseen_values, input no_return,
                  output ready);
  modport monitor (input valid, input cycle_steps, input most_occurrences,
                   input fewest_occurrences, input unseen_values, input no_return,
                   input ready);
endinterface

/* design/lfsr_cycle_occurrence_stats_core.sv */
// Channel  Dir  Fields                                              Accepted when
// req_i    in   wanted_count                                        valid && ready
// rsp_o    out  cycle_steps, most_occurrences, fewest_occurrences,  valid && ready
//               unseen_values, no_return
// Per request: one LFSR step per cycle until the seed recurs or every state has been
// stepped, then a radix-2 restoring divider only when the seed recurred.
// One request in flight; the sequencer sits in fetch, which is the only step with ready.
// A finished result sits in the output register; the next request is taken while it waits.
// An output stall holds the sequencer in its emit step only when a second result is ready.
// Reset is asynchronous, active low, and restores the config registers to their defaults.
module lfsr_cycle_occurrence_stats_core
  import lcos_pkg::*;
#(
  parameter int MAX_LENGTH = MAX_LENGTH_DEF,
  parameter int TAP_COUNT  = TAP_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  lcos_req_if.sink              req_i,
  lcos_rsp_if.source            rsp_o
);

  // Register width and tap count actually built.
  localparam int REG_W = (MAX_LENGTH < 32) ? MAX_LENGTH : 32;
  localparam int N_TAP = (TAP_COUNT < MAX_TAPS) ? TAP_COUNT : MAX_TAPS;

  logic [LEN_CFG_W-1:0] len_q;
  logic [TAP_CFG_W-1:0] tap_q [N_TAP];
  logic [SEED_W-1:0]    seed_q;
  logic [LEN_CFG_W-1:0] len_eff;

  status_t status;
  uword_t  uword;

  // Config writes: unknown indexes fall through and change nothing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= LEN_RST;
      seed_q <= SEED_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LENGTH: len_q  <= cfg_data_i[LEN_CFG_W-1:0];
        CFG_START:  seed_q <= cfg_data_i[SEED_W-1:0];
        default: ;
      endcase
    end
  end

  // Taps past the built count are never stored.
  for (genvar g = 0; g < N_TAP; g++) begin : g_tap
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tap_q[g] <= TAP_RST[g];
      end else if (cfg_we_i && cfg_idx_i == CFG_IDX_W'(CFG_TAP1 + g)) begin
        tap_q[g] <= cfg_data_i[TAP_CFG_W-1:0];
      end
    end
  end

  // Length 0 behaves as 1; anything over the built width is clamped.
  always_comb begin
    if (len_q == '0) begin
      len_eff = LEN_CFG_W'(1);
    end else if (len_q > LEN_CFG_W'(REG_W)) begin
      len_eff = LEN_CFG_W'(REG_W);
    end else begin
      len_eff = len_q;
    end
  end

  lcos_ucode_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .uword_o  (uword)
  );

  lcos_datapath #(
    .REG_W (REG_W),
    .N_TAP (N_TAP)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (uword.op),
    .len_i    (len_eff),
    .taps_i   (tap_q),
    .seed_i   (seed_q[REG_W-1:0]),
    .status_o (status),
    .req_i    (req_i),
    .rsp_o    (rsp_o)
  );

endmodule

/* design/lcos_ucode_seq.sv */
module lcos_ucode_seq
  import lcos_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output uword_t  uword_o
);

  step_e  upc_q, upc_d;
  uword_t uw;
  logic   taken;

  always_comb begin
    uw = ucode_rom(upc_q);
    case (uw.cond)
      COND_NONE:     taken = 1'b0;
      COND_ALWAYS:   taken = 1'b1;
      COND_NO_TXN:   taken = !status_i.in_valid;
      COND_LOOP:     taken = status_i.loop_more;
      COND_MISS:     taken = !status_i.found;
      COND_DIV_MORE: taken = status_i.div_more;
      COND_OUT_BUSY: taken = status_i.out_busy;
      default:       taken = 1'b1;
    endcase
    upc_d = taken ? uw.target : step_e'(upc_q + STEP_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= STEP_FETCH;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign uword_o = uw;

endmodule

/* design/lcos_datapath.sv */
module lcos_datapath
  import lcos_pkg::*;
#(
  parameter int REG_W = 32,
  parameter int N_TAP = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_op_e               op_i,
  input  logic [LEN_CFG_W-1:0] len_i,
  input  logic [TAP_CFG_W-1:0] taps_i [N_TAP],
  input  logic [REG_W-1:0]     seed_i,
  output status_t              status_o,
  lcos_req_if.sink             req_i,
  lcos_rsp_if.source           rsp_o
);

  localparam int CNT_W = REG_W + 1;
  localparam int IDX_W = $clog2(REG_W);

  logic [REG_W-1:0]     reg_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 found_q;
  logic [WANT_W-1:0]    quo_q;
  logic [CNT_W-1:0]     rem_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;

  logic                 out_valid_q;
  logic [CYC_W-1:0]     cyc_q;
  logic [OCC_W-1:0]     most_q;
  logic [OCC_W-1:0]     fewest_q;
  logic [OCC_W-1:0]     unseen_q;
  logic                 noret_q;

  logic [CNT_W-1:0]     space;
  logic [REG_W-1:0]     mask;
  logic [REG_W-1:0]     head;
  logic [REG_W-1:0]     seed_m;
  logic                 parity;
  logic [LEN_CFG_W-1:0] tap_idx [N_TAP];
  logic [REG_W-1:0]     reg_nx;
  logic [CNT_W-1:0]     cnt_nx;
  logic                 hit;
  logic [CNT_W:0]       rs;
  logic [CNT_W:0]       dvs;
  logic [CNT_W:0]       diff;
  logic                 ge;
  logic                 load;
  logic                 out_load;

  always_comb begin
    space  = CNT_W'(1) << len_i;
    mask   = REG_W'(space - CNT_W'(1));
    head   = REG_W'(space >> 1);
    seed_m = seed_i & mask;
    parity = 1'b0;
    for (int i = 0; i < N_TAP; i++) begin
      tap_idx[i] = len_i - taps_i[i];
      if (taps_i[i] != '0 && taps_i[i] <= len_i) begin
        parity = parity ^ reg_q[tap_idx[i][IDX_W-1:0]];
      end
    end
    reg_nx = ((reg_q & mask) >> 1) | (parity ? head : '0);
    cnt_nx = cnt_q + CNT_W'(1);
    hit    = (reg_nx == seed_m);
    // one restoring division step
    rs     = {rem_q, quo_q[WANT_W-1]};
    dvs    = {1'b0, cnt_q};
    diff   = rs - dvs;
    ge     = (rs >= dvs);
  end

  assign load     = (op_i == OP_LOAD) && req_i.valid;
  assign out_load = (op_i == OP_EMIT) && (!out_valid_q || rsp_o.ready);

  assign req_i.ready = (op_i == OP_LOAD);

  assign status_o.in_valid  = req_i.valid;
  assign status_o.loop_more = !hit && (cnt_nx != space);
  assign status_o.found     = found_q;
  assign status_o.div_more  = (div_cnt_q != '0);
  assign status_o.out_busy  = out_valid_q && !rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_q     <= '0;
      cnt_q     <= '0;
      found_q   <= 1'b0;
      div_cnt_q <= '0;
    end else begin
      case (op_i)
        OP_LOAD: begin
          if (load) begin
            reg_q     <= seed_m;
            cnt_q     <= '0;
            found_q   <= 1'b0;
            div_cnt_q <= DIV_CNT_W'(WANT_W - 1);
          end
        end
        OP_ADVANCE: begin
          reg_q   <= reg_nx;
          cnt_q   <= cnt_nx;
          found_q <= hit;
        end
        OP_DIV: begin
          div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      quo_q <= req_i.wanted_count;
      rem_q <= '0;
    end else if (op_i == OP_DIV) begin
      quo_q <= {quo_q[WANT_W-2:0], ge};
      rem_q <= ge ? diff[CNT_W-1:0] : rs[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (found_q) begin
        cyc_q    <= CYC_W'(cnt_q);
        most_q   <= quo_q + OCC_W'(rem_q != '0);
        fewest_q <= quo_q;
        unseen_q <= OCC_W'(space - cnt_q);
        noret_q  <= 1'b0;
      end else begin
        cyc_q    <= '0;
        most_q   <= '0;
        fewest_q <= '0;
        unseen_q <= '0;
        noret_q  <= 1'b1;
      end
    end
  end

  assign rsp_o.valid              = out_valid_q;
  assign rsp_o.cycle_steps        = cyc_q;
  assign rsp_o.most_occurrences   = most_q;
  assign rsp_o.fewest_occurrences = fewest_q;
  assign rsp_o.unseen_values      = unseen_q;
  assign rsp_o.no_return          = noret_q;

endmodule

/* design/lcos_checker.sv */
`include "lfsr_cycle_occurrence_stats_core_assert.svh"

module lcos_checker
  import lcos_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             req_valid_i,
  input logic             req_ready_i,
  input logic             rsp_valid_i,
  input logic             rsp_ready_i,
  input logic [CYC_W-1:0] rsp_cycle_steps_i,
  input logic [OCC_W-1:0] rsp_most_i,
  input logic [OCC_W-1:0] rsp_fewest_i,
  input logic [OCC_W-1:0] rsp_unseen_i,
  input logic             rsp_no_return_i
);

  logic                       req_take;
  logic                       rsp_stall;
  logic                       rsp_noret;
  logic                       rsp_zero;
  logic [CYC_W+3*OCC_W:0]     rsp_payload;

  assign req_take    = req_valid_i && req_ready_i;
  assign rsp_stall   = rsp_valid_i && !rsp_ready_i;
  assign rsp_noret   = rsp_valid_i && rsp_no_return_i;
  assign rsp_zero    = (rsp_cycle_steps_i == '0) && (rsp_most_i == '0) &&
                       (rsp_fewest_i == '0) && (rsp_unseen_i == '0);
  assign rsp_payload = {rsp_cycle_steps_i, rsp_most_i, rsp_fewest_i, rsp_unseen_i,
                        rsp_no_return_i};

  `LCOS_ASSERT_ALWAYS(a_rst_no_rsp, clk_i, !rst_ni |-> !rsp_valid_i)

  // one request in flight
  `LCOS_ASSERT(a_one_in_flight, clk_i, rst_ni, req_take |=> !req_ready_i)

  // a fresh result comes out while the sequencer is still past fetch
  `LCOS_ASSERT(a_rsp_rise_busy, clk_i, rst_ni, $rose(rsp_valid_i) |-> !req_ready_i)

  `LCOS_ASSERT(a_noret_zero, clk_i, rst_ni, rsp_noret |-> rsp_zero)

  `LCOS_ASSERT(a_rsp_hold, clk_i, rst_ni, rsp_stall |=> (rsp_valid_i && $stable(rsp_payload)))

endmodule

bind lfsr_cycle_occurrence_stats_core lcos_checker u_lcos_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_cycle_steps_i (rsp_o.cycle_steps),
  .rsp_most_i        (rsp_o.most_occurrences),
  .rsp_fewest_i      (rsp_o.fewest_occurrences),
  .rsp_unseen_i      (rsp_o.unseen_values),
  .rsp_no_return_i   (rsp_o.no_return)
);
